@@ rtl/vt4_pkg.sv @@
// vt4_pkg: shared types and constants for the 4x4 vertex transform
// no dependencies; used by every module under rtl

package vt4_pkg;

  localparam int unsigned NUM_COLS  = 4;
  localparam int unsigned COMP_W    = 16;
  localparam int unsigned COL_W     = NUM_COLS * COMP_W;
  localparam int unsigned PROD_W    = 2 * COMP_W;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned Q_SHIFT   = 8;
  localparam int unsigned SHR_W     = SUM_W - Q_SHIFT;
  localparam int unsigned CFG_IDX_W = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_3 = 8'd3;

  // reset values form the identity matrix (1.0 on the diagonal)
  localparam logic [COL_W-1:0] COLUMN_0_RST = 64'h0000_0000_0000_0100;
  localparam logic [COL_W-1:0] COLUMN_1_RST = 64'h0000_0000_0100_0000;
  localparam logic [COL_W-1:0] COLUMN_2_RST = 64'h0000_0100_0000_0000;
  localparam logic [COL_W-1:0] COLUMN_3_RST = 64'h0100_0000_0000_0000;

  // saturation limits of a q8.8 component
  localparam logic signed [SHR_W-1:0] SAT_MAX = 26'sd32767;
  localparam logic signed [SHR_W-1:0] SAT_MIN = -26'sd32768;

  typedef logic signed [COMP_W-1:0] q88_t;
  typedef logic [NUM_COLS-1:0][COMP_W-1:0] vec4_t;

  // one lane's finished component
  typedef struct packed {
    logic [COMP_W-1:0] value;
    logic              sat;
  } lane_res_t;

endpackage

@@ rtl/vt4_lane.sv @@
// vt4_lane: one output component, a row of the matrix dotted with the vector
// depends on vt4_pkg; two register stages (products, then shifted saturated sum)

module vt4_lane (
  input  logic                clk,
  input  logic                en,
  input  vt4_pkg::vec4_t      vec,
  input  vt4_pkg::vec4_t      coef,
  output vt4_pkg::lane_res_t  res
);

  logic signed [vt4_pkg::PROD_W-1:0] prod_r [vt4_pkg::NUM_COLS];
  logic signed [vt4_pkg::SUM_W-1:0]  sum;
  logic signed [vt4_pkg::SHR_W-1:0]  shr;
  vt4_pkg::lane_res_t                res_nxt;
  vt4_pkg::lane_res_t                res_r;

  // stage 1: four full-precision products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < vt4_pkg::NUM_COLS; j++) begin
        prod_r[j] <= $signed(coef[j]) * $signed(vec[j]);
      end
    end
  end

  // stage 2: exact sum, arithmetic shift to q8.8, saturate
  always_comb begin
    sum = '0;
    for (int j = 0; j < vt4_pkg::NUM_COLS; j++) begin
      sum = sum + {{(vt4_pkg::SUM_W - vt4_pkg::PROD_W){prod_r[j][vt4_pkg::PROD_W-1]}},
                   prod_r[j]};
    end
    shr = sum[vt4_pkg::SUM_W-1:vt4_pkg::Q_SHIFT];
    if (shr > vt4_pkg::SAT_MAX) begin
      res_nxt.value = vt4_pkg::SAT_MAX[vt4_pkg::COMP_W-1:0];
      res_nxt.sat   = 1'b1;
    end else if (shr < vt4_pkg::SAT_MIN) begin
      res_nxt.value = vt4_pkg::SAT_MIN[vt4_pkg::COMP_W-1:0];
      res_nxt.sat   = 1'b1;
    end else begin
      res_nxt.value = shr[vt4_pkg::COMP_W-1:0];
      res_nxt.sat   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ rtl/vt4_merge.sv @@
// vt4_merge: output register that gathers the four lane results
// depends on vt4_pkg; ors the lane saturation flags into one overflow bit

module vt4_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_in,
  input  vt4_pkg::lane_res_t [vt4_pkg::NUM_COLS-1:0] lane_res,
  output logic                          out_valid,
  output vt4_pkg::vec4_t                out_vec,
  output logic                          out_ovf
);

  logic           valid_r;
  vt4_pkg::vec4_t vec_r;
  vt4_pkg::vec4_t vec_nxt;
  logic           ovf_r;
  logic           ovf_nxt;

  // combine lanes
  always_comb begin
    ovf_nxt = 1'b0;
    for (int i = 0; i < vt4_pkg::NUM_COLS; i++) begin
      vec_nxt[i] = lane_res[i].value;
      ovf_nxt    = ovf_nxt | lane_res[i].sat;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;
  assign out_ovf   = ovf_r;

endmodule

@@ rtl/vertex_transform_4x4.sv @@
// vertex_transform_4x4: 4x4 q8.8 matrix times homogeneous vector, saturated
// registered stages from request accepted to result valid: products, sum, output
// throughput one request per cycle while the output is not stalled; four lanes, one per output component
// the whole pipeline holds while a result waits and out_ready is low
// synchronous active-low reset clears valid bits and loads the identity matrix
// depends on vt4_pkg, vt4_lane, vt4_merge

module vertex_transform_4x4 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                in_x,
  input  logic signed [15:0]                in_y,
  input  logic signed [15:0]                in_z,
  input  logic signed [15:0]                in_w,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                out_x,
  output logic signed [15:0]                out_y,
  output logic signed [15:0]                out_z,
  output logic signed [15:0]                out_w,
  output logic                              out_overflow,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vt4_pkg::COL_W-1:0]         cfg_data
);

  logic [vt4_pkg::COL_W-1:0] col_r [vt4_pkg::NUM_COLS];
  logic                      adv;
  logic                      v1_r;
  logic                      v2_r;
  vt4_pkg::vec4_t            vec;
  vt4_pkg::vec4_t            coef [vt4_pkg::NUM_COLS];
  vt4_pkg::lane_res_t [vt4_pkg::NUM_COLS-1:0] lane_res;
  vt4_pkg::vec4_t            res_vec;

  assign cfg_ready = 1'b1;

  // column registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r[0] <= vt4_pkg::COLUMN_0_RST;
      col_r[1] <= vt4_pkg::COLUMN_1_RST;
      col_r[2] <= vt4_pkg::COLUMN_2_RST;
      col_r[3] <= vt4_pkg::COLUMN_3_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        vt4_pkg::CFG_COLUMN_0: col_r[0] <= cfg_data;
        vt4_pkg::CFG_COLUMN_1: col_r[1] <= cfg_data;
        vt4_pkg::CFG_COLUMN_2: col_r[2] <= cfg_data;
        vt4_pkg::CFG_COLUMN_3: col_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output slot is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = in_w;

  // lane i takes component i of every column
  for (genvar i = 0; i < vt4_pkg::NUM_COLS; i++) begin : g_lane
    for (genvar j = 0; j < vt4_pkg::NUM_COLS; j++) begin : g_coef
      assign coef[i][j] = col_r[j][vt4_pkg::COMP_W*i +: vt4_pkg::COMP_W];
    end

    vt4_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .vec  (vec),
      .coef (coef[i]),
      .res  (lane_res[i])
    );
  end

  // gather lanes into the output register
  vt4_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .valid_in  (v2_r),
    .lane_res  (lane_res),
    .out_valid (out_valid),
    .out_vec   (res_vec),
    .out_ovf   (out_overflow)
  );

  assign out_x = res_vec[0];
  assign out_y = res_vec[1];
  assign out_z = res_vec[2];
  assign out_w = res_vec[3];

endmodule

@@ verif/vertex_transform_4x4_tb.sv @@
// vertex_transform_4x4_tb: self-checking bench for the q8.8 4x4 vertex transform
// random idling on both handshakes, column reloads between phases, scoreboard check
// depends on vt4_pkg and vertex_transform_4x4 under rtl
`timescale 1ns / 1ps

module vertex_transform_4x4_tb;

  localparam int unsigned CLK_HALF_NS      = 5;
  localparam int unsigned TIMEOUT_CYCLES   = 200_000;
  localparam int unsigned MAX_IDLE         = 5;
  localparam int unsigned PIPE_SLACK       = 8;
  localparam int unsigned RAND_PHASES      = 8;
  localparam int unsigned PHASE_VERTICES   = 104;
  localparam int unsigned BURST_PHASE      = 2;
  localparam int unsigned HOLD_PHASE       = 5;
  localparam int unsigned HOLD_LEAD_CYCLES = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 150;

  // indexes that map to no column
  localparam logic [vt4_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LOW = vt4_pkg::CFG_COLUMN_3 + 1'b1;
  localparam logic [vt4_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_TOP = '1;

  typedef struct packed {
    vt4_pkg::vec4_t comp;
    logic           ovf;
  } xformed_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [15:0]            in_x = '0;
  logic signed [15:0]            in_y = '0;
  logic signed [15:0]            in_z = '0;
  logic signed [15:0]            in_w = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [15:0]            out_x;
  logic signed [15:0]            out_y;
  logic signed [15:0]            out_z;
  logic signed [15:0]            out_w;
  logic                          out_overflow;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [vt4_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vt4_pkg::COL_W-1:0]     cfg_data;

  // predictor copy of the column registers, [column][lane]
  logic [vt4_pkg::NUM_COLS-1:0][vt4_pkg::NUM_COLS-1:0][vt4_pkg::COMP_W-1:0] matrix_cols;

  vt4_pkg::vec4_t pending_vertices[$];
  xformed_t       transformed_due[$];
  int unsigned    vertices_issued = 0;
  int unsigned    results_seen    = 0;
  int unsigned    mismatches      = 0;
  int unsigned    tx_idle         = 0;
  int unsigned    rx_idle         = 0;
  logic           sender_burst    = 1'b0;
  logic           receiver_burst  = 1'b0;
  logic           long_hold_armed = 1'b0;
  logic           out_hold        = 1'b0;

  vertex_transform_4x4 dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_z         (in_z),
    .in_w         (in_w),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_w        (out_w),
    .out_overflow (out_overflow),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #(CLK_HALF_NS) clk = 1'b1;
    #(CLK_HALF_NS) clk = 1'b0;
  end

  // exact q16.16 dot products, floor shift to q8.8, clamp each lane
  function automatic xformed_t transform_vertex(input vt4_pkg::vec4_t v);
    xformed_t           res;
    logic signed [47:0] acc;
    logic signed [47:0] coef;
    logic signed [47:0] comp;
    logic signed [47:0] scaled;
    int                 i;
    int                 j;
    res = '0;
    for (i = 0; i < vt4_pkg::NUM_COLS; i++) begin
      acc = '0;
      for (j = 0; j < vt4_pkg::NUM_COLS; j++) begin
        coef = $signed(matrix_cols[j][i]);
        comp = $signed(v[j]);
        acc  = acc + coef * comp;
      end
      scaled = acc >>> vt4_pkg::Q_SHIFT;
      if (scaled > vt4_pkg::SAT_MAX) begin
        res.comp[i] = vt4_pkg::SAT_MAX[vt4_pkg::COMP_W-1:0];
        res.ovf     = 1'b1;
      end else if (scaled < vt4_pkg::SAT_MIN) begin
        res.comp[i] = vt4_pkg::SAT_MIN[vt4_pkg::COMP_W-1:0];
        res.ovf     = 1'b1;
      end else begin
        res.comp[i] = scaled[vt4_pkg::COMP_W-1:0];
      end
    end
    return res;
  endfunction

  // matrix coefficients: mostly within +-2.0, some full range and extremes
  function automatic vt4_pkg::q88_t matrix_entry();
    case ($urandom_range(0, 9))
      5, 6, 7: return vt4_pkg::q88_t'($urandom);
      8:       return 16'sh7FFF;
      9:       return 16'sh8000;
      default: return vt4_pkg::q88_t'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  function automatic logic [vt4_pkg::COL_W-1:0] random_column();
    vt4_pkg::vec4_t col;
    int             i;
    for (i = 0; i < vt4_pkg::NUM_COLS; i++) begin
      col[i] = matrix_entry();
    end
    return col;
  endfunction

  // vector components: mostly full range, some small, some extremes
  function automatic vt4_pkg::q88_t vertex_entry();
    case ($urandom_range(0, 9))
      6, 7:    return vt4_pkg::q88_t'($urandom_range(0, 4095) - 2048);
      8:       return 16'sh7FFF;
      9:       return 16'sh8000;
      default: return vt4_pkg::q88_t'($urandom);
    endcase
  endfunction

  task automatic queue_vertex(input vt4_pkg::q88_t x, input vt4_pkg::q88_t y,
                              input vt4_pkg::q88_t z, input vt4_pkg::q88_t w);
    pending_vertices.push_back({w, z, y, x});
    vertices_issued++;
  endtask

  // one register write, called at a rising edge while the block is idle
  task automatic write_reg(input logic [vt4_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vt4_pkg::COL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vt4_pkg::CFG_COLUMN_0: matrix_cols[0] = data;
      vt4_pkg::CFG_COLUMN_1: matrix_cols[1] = data;
      vt4_pkg::CFG_COLUMN_2: matrix_cols[2] = data;
      vt4_pkg::CFG_COLUMN_3: matrix_cols[3] = data;
      default: ;  // unmapped index leaves the matrix alone
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_matrix(input logic [vt4_pkg::COL_W-1:0] c0,
                             input logic [vt4_pkg::COL_W-1:0] c1,
                             input logic [vt4_pkg::COL_W-1:0] c2,
                             input logic [vt4_pkg::COL_W-1:0] c3);
    write_reg(vt4_pkg::CFG_COLUMN_0, c0);
    write_reg(vt4_pkg::CFG_COLUMN_1, c1);
    write_reg(vt4_pkg::CFG_COLUMN_2, c2);
    write_reg(vt4_pkg::CFG_COLUMN_3, c3);
  endtask

  // wait for every queued request to come back, then let the pipe empty
  task automatic settle_pipeline();
    while (results_seen != vertices_issued) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic check_field(input string name, input vt4_pkg::q88_t got,
                             input vt4_pkg::q88_t want);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // request driver, predicts each accepted vertex
  always @(posedge clk) begin : vertex_driver
    vt4_pkg::vec4_t next_v;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_idle  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        transformed_due.push_back(transform_vertex({in_w, in_z, in_y, in_x}));
      end
      if (!in_valid || in_ready) begin
        if (tx_idle > 0) begin
          in_valid <= 1'b0;
          tx_idle  <= tx_idle - 1;
        end else if (pending_vertices.size() != 0) begin
          next_v   = pending_vertices.pop_front();
          in_x     <= next_v[0];
          in_y     <= next_v[1];
          in_z     <= next_v[2];
          in_w     <= next_v[3];
          in_valid <= 1'b1;
          tx_idle  <= sender_burst ? 0 : $urandom_range(0, MAX_IDLE);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin : result_monitor
    xformed_t    want;
    int unsigned hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_idle   <= 0;
    end else begin
      hold = rx_idle;
      if (out_valid && out_ready) begin
        results_seen++;
        if (transformed_due.size() == 0) begin
          $error("unexpected result: x %0d y %0d z %0d w %0d", out_x, out_y, out_z, out_w);
          mismatches++;
        end else begin
          want = transformed_due.pop_front();
          check_field("out_x", out_x, want.comp[0]);
          check_field("out_y", out_y, want.comp[1]);
          check_field("out_z", out_z, want.comp[2]);
          check_field("out_w", out_w, want.comp[3]);
          if (out_overflow !== want.ovf) begin
            $error("out_overflow mismatch: expected %0d, got %0d", want.ovf, out_overflow);
            mismatches++;
          end
        end
        hold = receiver_burst ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        rx_idle   <= hold - 1;
      end else begin
        out_ready <= !out_hold;
        rx_idle   <= 0;
      end
    end
  end

  // long receiver stall so the pipe fills and in_ready drops
  initial begin : receiver_hold_off
    wait (long_hold_armed);
    repeat (HOLD_LEAD_CYCLES) @(posedge clk);
    out_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned k;
    int unsigned junk_idx;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    matrix_cols = {vt4_pkg::COLUMN_3_RST, vt4_pkg::COLUMN_2_RST,
                   vt4_pkg::COLUMN_1_RST, vt4_pkg::COLUMN_0_RST};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity after reset passes vectors through
    queue_vertex(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    queue_vertex(16'sh7FFF, 16'sh8000, 16'sh0001, -16'sd1);
    queue_vertex(16'sh8000, 16'sh7FFF, -16'sd1, 16'sh0001);
    queue_vertex(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
    settle_pipeline();

    // largest positive coefficients: saturation both ways, unmapped write ignored
    load_matrix({4{16'sh7FFF}}, {4{16'sh7FFF}}, {4{16'sh7FFF}}, {4{16'sh7FFF}});
    write_reg(CFG_UNMAPPED_TOP, '0);
    queue_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_vertex(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    queue_vertex(16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000);
    queue_vertex(16'sh0001, 16'sh0001, 16'sh0000, 16'sh0000);
    settle_pipeline();

    // most negative coefficients: -128.0 times 1.0 lands exactly on the limit
    load_matrix({4{16'sh8000}}, {4{16'sh8000}}, {4{16'sh8000}}, {4{16'sh8000}});
    queue_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_vertex(16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000);
    settle_pipeline();

    // one lsb coefficient shows the floor of the shift on negative sums
    load_matrix({4{16'sh0001}}, '0, '0, '0);
    write_reg(CFG_UNMAPPED_LOW, '1);
    queue_vertex(-16'sd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_vertex(16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000);
    queue_vertex(-16'sd256, 16'sh0000, 16'sh0000, 16'sh0000);
    queue_vertex(-16'sd257, 16'sh0000, 16'sh0000, 16'sh0000);
    settle_pipeline();

    // all-ones columns, each coefficient -1/256
    load_matrix('1, '1, '1, '1);
    queue_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    settle_pipeline();

    // random matrices and vectors, one phase per matrix
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      sender_burst   = (ph == BURST_PHASE) || (ph == HOLD_PHASE);
      receiver_burst = sender_burst;
      load_matrix(random_column(), random_column(), random_column(), random_column());
      if ($urandom_range(0, 2) == 0) begin
        junk_idx = $urandom_range(CFG_UNMAPPED_LOW, CFG_UNMAPPED_TOP);
        write_reg(junk_idx[vt4_pkg::CFG_IDX_W-1:0], {$urandom, $urandom});
      end
      if (ph == HOLD_PHASE) begin
        long_hold_armed = 1'b1;
      end
      for (k = 0; k < PHASE_VERTICES; k++) begin
        queue_vertex(vertex_entry(), vertex_entry(), vertex_entry(), vertex_entry());
      end
      settle_pipeline();
    end

    if (mismatches == 0 && transformed_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
